// ===== src/sacts_pkg.sv =====
package sacts_pkg;

  // Field widths of one transaction.
  localparam int unsigned AddrW = 32;
  localparam int unsigned TagW  = 32;
  localparam int unsigned SetOutW = 8;

  // Configuration register indexes.
  localparam logic [2:0] CfgPolicy = 3'd0;
  localparam logic [2:0] CfgWbMode = 3'd1;
  localparam logic [2:0] CfgOffset = 3'd2;
  localparam logic [2:0] CfgSetBits = 3'd3;
  localparam logic [2:0] CfgWayBits = 3'd4;
  localparam logic [2:0] CfgSeed   = 3'd5;

  // Replacement policy codes. The spare code behaves as LRU.
  localparam logic [1:0] PolLru    = 2'd0;
  localparam logic [1:0] PolFifo   = 2'd1;
  localparam logic [1:0] PolRandom = 2'd2;
  localparam logic [1:0] PolLruAlt = 2'd3;

  // Galois LFSR taps.
  localparam logic [15:0] LfsrTaps = 16'hB400;

  typedef struct packed {
    logic [AddrW-1:0] address;
    logic             is_write;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [SetOutW-1:0] set_index;
    logic [TagW-1:0]    tag_value;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch request and start set read
    logic update;   // compare and write the set back
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic rsp_full;
    logic clearing;  // valid bits are still being cleared after reset
  } dp_status_t;

endpackage

// ===== src/sacts_ctrl.sv =====
module sacts_ctrl
  import sacts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_stall_o,
  input  dp_status_t status_i,
  output ctl_cmd_t   cmd_o
);

  localparam logic [0:0] StIdle = 1'b0;
  localparam logic [0:0] StUpd  = 1'b1;

  logic [0:0] state_q, state_d;

  // A new request is taken only in idle, once the valid bits are cleared,
  // and only while the result slot can absorb the update that follows.
  assign req_stall_o   = (state_q != StIdle) || status_i.rsp_full || status_i.clearing;
  assign cmd_o.capture = req_valid_i && !req_stall_o;
  assign cmd_o.update  = (state_q == StUpd);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (cmd_o.capture) state_d = StUpd;
      StUpd:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // An update always follows a capture in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.update)
    else $error("update did not follow capture");

  // No capture while an update is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |-> !cmd_o.capture)
    else $error("capture during update");

  // Captures only happen with the result slot free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> !status_i.rsp_full)
    else $error("capture with full result slot");

  // No capture while the valid bits are being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> !status_i.clearing)
    else $error("capture during clearing pass");

endmodule

// ===== src/sacts_datapath.sv =====
module sacts_datapath
  import sacts_pkg::*;
#(
  parameter int unsigned SetCount = 256,
  parameter int unsigned WayCount = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_cmd_t    cmd_i,
  output dp_status_t  status_o,
  input  req_t        req_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output rsp_t        rsp_o
);

  localparam int unsigned SetW  = (SetCount > 1) ? $clog2(SetCount) : 1;
  localparam int unsigned WayW  = (WayCount > 1) ? $clog2(WayCount) : 1;
  // Largest field widths whose sets and ways all exist (floor of log2).
  localparam int unsigned MaxSb = $clog2(SetCount + 1) - 1;
  localparam int unsigned MaxWb = $clog2(WayCount + 1) - 1;

  // Configuration registers.
  logic [1:0]  policy_q;
  logic        wb_mode_q;
  logic [3:0]  offset_q;
  logic [3:0]  set_bits_q;
  logic [1:0]  way_bits_q;
  logic [15:0] lfsr_q, lfsr_d;

  // Tag and valid memories: one row per set, all ways side by side.
  logic [TagW-1:0]     tag_mem [SetCount][WayCount];
  logic [WayCount-1:0] valid_mem [SetCount];
  logic [TagW-1:0]     row_tag_q [WayCount];
  logic [WayCount-1:0] row_vld_q;

  // Clearing pass over the valid memory after reset.
  logic            clr_busy_q;
  logic [SetW-1:0] clr_idx_q;

  // Latched request fields.
  logic [SetW-1:0] set_q;
  logic [TagW-1:0] tag_q;
  logic            wr_q;

  // Result slot.
  logic rsp_valid_q;
  rsp_t rsp_q;

  // Field split of the incoming address.
  logic [3:0]       sb_eff;
  logic [1:0]       wb_eff;
  logic [5:0]       tag_sh;
  logic [AddrW-1:0] set_full;
  logic [SetW-1:0]  set_c;
  logic [TagW-1:0]  tag_c;

  always_comb begin
    sb_eff   = (32'(set_bits_q) > MaxSb) ? 4'(MaxSb) : set_bits_q;
    wb_eff   = (32'(way_bits_q) > MaxWb) ? 2'(MaxWb) : way_bits_q;
    set_full = (req_i.address >> offset_q) & ((AddrW'(1) << sb_eff) - AddrW'(1));
    set_c    = SetW'(set_full);
    tag_sh   = 6'(offset_q) + 6'(sb_eff);
    tag_c    = TagW'({32'd0, req_i.address} >> tag_sh);
  end

  // Hit search over the ways in use, then the reordered row.
  logic [4:0]          ways;
  logic                hit;
  logic [WayW-1:0]     pos;
  logic                alloc, is_lru, do_write;
  logic [15:0]         lfsr_nx;
  logic [WayW-1:0]     victim;
  logic [TagW-1:0]     new_tag [WayCount];
  logic [WayCount-1:0] new_vld;
  logic [WayW-1:0]     src;
  logic [4:0]          last;

  always_comb begin
    ways = 5'd1 << wb_eff;
    last = ways - 5'd1;
    hit  = 1'b0;
    pos  = '0;
    for (int i = WayCount - 1; i >= 0; i--) begin
      if (5'(i) < ways && row_vld_q[i] && row_tag_q[i] == tag_q) begin
        hit = 1'b1;
        pos = WayW'(i);
      end
    end
    alloc   = wb_mode_q || !wr_q;
    is_lru  = (policy_q == PolLru) || (policy_q == PolLruAlt);
    lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ LfsrTaps) : (lfsr_q >> 1);
    victim  = WayW'(lfsr_nx) & WayW'(last);
    src     = hit ? pos : '0;
    new_tag = row_tag_q;
    new_vld = row_vld_q;
    do_write = 1'b0;
    lfsr_d  = lfsr_q;
    if (hit && is_lru) begin
      do_write = 1'b1;
    end else if (!hit && alloc && policy_q != PolRandom) begin
      do_write = 1'b1;
    end
    // Shift entries between the source and the last position down by one.
    if (do_write) begin
      for (int j = 0; j < WayCount; j++) begin
        if (5'(j) >= 5'(src) && 5'(j) < last && j + 1 < WayCount) begin
          new_tag[j] = row_tag_q[(j + 1) % WayCount];
          new_vld[j] = row_vld_q[(j + 1) % WayCount];
        end else if (5'(j) == last) begin
          new_tag[j] = hit ? row_tag_q[pos] : tag_q;
          new_vld[j] = hit ? row_vld_q[pos] : 1'b1;
        end
      end
    end
    if (!hit && alloc && policy_q == PolRandom) begin
      do_write        = 1'b1;
      lfsr_d          = lfsr_nx;
      new_tag[victim] = tag_q;
      new_vld[victim] = 1'b1;
    end
  end

  // Memory read on capture, write back on update, clearing pass after reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_tag_q <= tag_mem[set_c];
      row_vld_q <= valid_mem[set_c];
    end
    if (cmd_i.update && do_write) begin
      tag_mem[set_q] <= new_tag;
    end
    if (clr_busy_q) begin
      valid_mem[clr_idx_q] <= '0;
    end else if (cmd_i.update && do_write) begin
      valid_mem[set_q] <= new_vld;
    end
    if (cmd_i.capture) begin
      set_q <= set_c;
      tag_q <= tag_c;
      wr_q  <= req_i.is_write;
    end
    if (cmd_i.update) begin
      rsp_q.hit       <= hit;
      rsp_q.set_index <= SetOutW'(32'(set_q));
      rsp_q.tag_value <= tag_q;
    end
  end

  // The clearing pass walks one set per cycle from reset release.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (32'(clr_idx_q) == SetCount - 1) clr_busy_q <= 1'b0;
      clr_idx_q <= clr_idx_q + SetW'(1);
    end
  end

  // Configuration, LFSR and result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= PolLru;
      wb_mode_q   <= 1'b1;
      offset_q    <= 4'd4;
      set_bits_q  <= 4'd8;
      way_bits_q  <= 2'd2;
      lfsr_q      <= 16'd1;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        lfsr_q <= lfsr_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPolicy:  policy_q   <= cfg_data_i[1:0];
          CfgWbMode:  wb_mode_q  <= cfg_data_i[0];
          CfgOffset:  offset_q   <= cfg_data_i[3:0];
          CfgSetBits: set_bits_q <= cfg_data_i[3:0];
          CfgWayBits: way_bits_q <= cfg_data_i[1:0];
          CfgSeed:    lfsr_q     <= (cfg_data_i == 16'd0) ? 16'd1 : cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.update) begin
        rsp_valid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.rsp_full = rsp_valid_q && rsp_stall_i;
  assign status_o.clearing = clr_busy_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // The LFSR never reaches zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni) lfsr_q != 16'd0)
    else $error("LFSR locked at zero");

  // A result appears the cycle after an update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> rsp_valid_o)
    else $error("result missing after update");

  // An update never overwrites a pending result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> !(rsp_valid_q && rsp_stall_i))
    else $error("result overwritten");

endmodule

// ===== src/set_assoc_cache_tag_store_top.sv =====
// Flow: an accepted transaction reads its set row on capture; the update state
// compares and writes back the row and registers the result in the output slot.
// No new transaction is taken until that update is done and the slot is free.
// Reset: asynchronous, active low; configuration returns to LRU, write-back,
// 16-byte blocks, 256 sets, 4 ways, seed 1. The valid bits are then cleared one
// set per cycle, and the input stalls until the clearing pass is done.
module set_assoc_cache_tag_store_top
  import sacts_pkg::*;
#(
  parameter int unsigned SET_COUNT = 256,
  parameter int unsigned WAY_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  req_t        req_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output rsp_t        rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  sacts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sacts_datapath #(
    .SetCount (SET_COUNT),
    .WayCount (WAY_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_i       (req_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i   (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

endmodule
